/* src/cvs_pkg.sv */
// Shared types, constants and helpers for the cell voltage statistics unit.
// No dependencies; every other file refers to it by scoped names.
package cvs_pkg;

    localparam int CodeW       = 16;
    localparam int IdxW        = 8;
    localparam int SumW        = 24;
    localparam int CfgIdxW     = 1;
    localparam int CellCountDefault = 16;

    localparam logic [IdxW-1:0]  NoIndex      = 8'hFF;
    localparam logic [CodeW-1:0] CodeMax      = 16'hFFFF;
    localparam logic [CodeW-1:0] LowBoundRst  = 16'd5000;
    localparam logic [CodeW-1:0] HighBoundRst = 16'd50000;

    // code / 10 == (code * 52429) >> 19 for every 16-bit code
    localparam logic [16:0] MvRecip = 17'd52429;
    localparam int          MvShift = 19;

    typedef enum logic [CfgIdxW-1:0] {
        CfgLowBound  = 1'b0,
        CfgHighBound = 1'b1
    } t_cfg_idx;

    // Truncated millivolts from a 100 uV code.
    function automatic logic [CodeW-1:0] code_to_mv(input logic [CodeW-1:0] code);
        logic [32:0] prod;
        prod = {17'b0, code} * {16'b0, MvRecip};
        return CodeW'(prod >> MvShift);
    endfunction

endpackage

/* src/cvs_stream_if.sv */
// Handshake interfaces for the input word, the result word and the config writes.
// Depends on cvs_pkg for field widths.
interface cvs_in_if;
    logic                      valid;
    logic                      ready;
    logic [cvs_pkg::CodeW-1:0] cell_code;
    modport source (output valid, output cell_code, input ready);
    modport sink   (input valid, input cell_code, output ready);
endinterface

interface cvs_out_if;
    logic                      valid;
    logic                      ready;
    logic [cvs_pkg::CodeW-1:0] min_voltage;
    logic [cvs_pkg::CodeW-1:0] max_voltage;
    logic [cvs_pkg::IdxW-1:0]  min_cell;
    logic [cvs_pkg::IdxW-1:0]  max_cell;
    logic [cvs_pkg::CodeW-1:0] pack_millivolts;
    logic                      invalid_seen;
    logic [cvs_pkg::IdxW-1:0]  invalid_cell;
    modport source (output valid, output min_voltage, output max_voltage, output min_cell,
                    output max_cell, output pack_millivolts, output invalid_seen,
                    output invalid_cell, input ready);
    modport sink   (input valid, input min_voltage, input max_voltage, input min_cell,
                    input max_cell, input pack_millivolts, input invalid_seen,
                    input invalid_cell, output ready);
endinterface

interface cvs_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [cvs_pkg::CfgIdxW-1:0] index;
    logic [cvs_pkg::CodeW-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/cell_voltage_statistics_unit.sv */
// Cell voltage statistics: running min/max with first index, invalid tracking, mV pack sum.
// Depends on cvs_pkg and the interfaces in cvs_stream_if.sv.
// Order: an accepted word is held in the input stage, then folded into the statistics; for the last
//   cell of a pack the result register is loaded in the same update that clears the statistics.
// Throughput: one cell word per cycle; only an untaken result stalls the last cell.
// Reset: synchronous, active low; bounds return to 5000 and 50000, statistics clear.
module cell_voltage_statistics_unit #(
    parameter int CELL_COUNT = cvs_pkg::CellCountDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cvs_in_if.sink       i_in,
    cvs_cfg_if.sink      i_cfg,
    cvs_out_if.source    o_out
);

    localparam logic [cvs_pkg::IdxW:0] LastPos = (cvs_pkg::IdxW+1)'(CELL_COUNT);

    // Config registers
    logic [cvs_pkg::CodeW-1:0] r_low, r_high;

    // Input stage: code plus its millivolt value, worked out on capture
    logic                      r_s1_valid;
    logic [cvs_pkg::CodeW-1:0] r_s1_code;
    logic [cvs_pkg::CodeW-1:0] r_s1_mv;

    // Running statistics
    logic [cvs_pkg::IdxW-1:0]  r_pos;
    logic [cvs_pkg::CodeW-1:0] r_min, r_max;
    logic [cvs_pkg::IdxW-1:0]  r_min_idx, r_max_idx;
    logic [cvs_pkg::SumW-1:0]  r_sum;
    logic                      r_inv_flag;
    logic [cvs_pkg::IdxW-1:0]  r_inv_idx;
    logic                      r_any;

    // Result register
    logic                      r_out_valid;
    logic [cvs_pkg::CodeW-1:0] r_out_min, r_out_max, r_out_mv;
    logic [cvs_pkg::IdxW-1:0]  r_out_min_idx, r_out_max_idx, r_out_inv_idx;
    logic                      r_out_inv;

    // Next values of the statistics with the staged word folded in
    logic                      n_any, n_inv_flag;
    logic [cvs_pkg::CodeW-1:0] n_min, n_max;
    logic [cvs_pkg::IdxW-1:0]  n_min_idx, n_max_idx, n_inv_idx;
    logic [cvs_pkg::SumW-1:0]  n_sum;

    logic in_window, s1_last, out_free, s1_adv, in_take;

    // Config writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= cvs_pkg::LowBoundRst;
            r_high <= cvs_pkg::HighBoundRst;
        end else if (i_cfg.valid) begin
            case (cvs_pkg::t_cfg_idx'(i_cfg.index))
                cvs_pkg::CfgLowBound:  r_low  <= i_cfg.data;
                cvs_pkg::CfgHighBound: r_high <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Handshake: the last cell of a pack waits only while an unread result blocks it
    assign s1_last  = ({1'b0, r_pos} + 9'd1) >= LastPos;
    assign out_free = !r_out_valid || o_out.ready;
    assign s1_adv   = r_s1_valid && (!s1_last || out_free);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_take  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_code <= i_in.cell_code;
            r_s1_mv   <= cvs_pkg::code_to_mv(i_in.cell_code);
        end
    end

    // Window check and extrema update; ties keep the earlier index
    always_comb begin
        in_window  = (r_s1_code > r_low) && (r_s1_code < r_high);
        n_any      = r_any | in_window;
        n_sum      = r_sum;
        n_min      = r_min;
        n_min_idx  = r_min_idx;
        n_max      = r_max;
        n_max_idx  = r_max_idx;
        n_inv_flag = r_inv_flag;
        n_inv_idx  = r_inv_idx;
        if (in_window) begin
            n_sum = r_sum + cvs_pkg::SumW'(r_s1_mv);
            if (r_s1_code > r_max) begin
                n_max     = r_s1_code;
                n_max_idx = r_pos;
            end
            if (r_s1_code < r_min) begin
                n_min     = r_s1_code;
                n_min_idx = r_pos;
            end
        end else begin
            n_inv_flag = 1'b1;
            n_inv_idx  = r_pos;
        end
    end

    // Statistics: advance on each word, clear after the last cell of a pack
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s1_adv && s1_last)) begin
            r_pos      <= '0;
            r_min      <= cvs_pkg::CodeMax;
            r_max      <= '0;
            r_min_idx  <= cvs_pkg::NoIndex;
            r_max_idx  <= cvs_pkg::NoIndex;
            r_sum      <= '0;
            r_inv_flag <= 1'b0;
            r_inv_idx  <= cvs_pkg::NoIndex;
            r_any      <= 1'b0;
        end else if (s1_adv) begin
            r_pos      <= r_pos + 8'd1;
            r_min      <= n_min;
            r_max      <= n_max;
            r_min_idx  <= n_min_idx;
            r_max_idx  <= n_max_idx;
            r_sum      <= n_sum;
            r_inv_flag <= n_inv_flag;
            r_inv_idx  <= n_inv_idx;
            r_any      <= n_any;
        end
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_last) begin
            r_out_inv     <= n_inv_flag;
            r_out_inv_idx <= n_inv_idx;
            if (n_any) begin
                r_out_min     <= n_min;
                r_out_max     <= n_max;
                r_out_min_idx <= n_min_idx;
                r_out_max_idx <= n_max_idx;
                // saturate the reported sum at 16 bits
                r_out_mv      <= (|n_sum[cvs_pkg::SumW-1:cvs_pkg::CodeW]) ?
                                 cvs_pkg::CodeMax : n_sum[cvs_pkg::CodeW-1:0];
            end else begin
                r_out_min     <= '0;
                r_out_max     <= '0;
                r_out_min_idx <= cvs_pkg::NoIndex;
                r_out_max_idx <= cvs_pkg::NoIndex;
                r_out_mv      <= '0;
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.min_voltage     = r_out_min;
    assign o_out.max_voltage     = r_out_max;
    assign o_out.min_cell        = r_out_min_idx;
    assign o_out.max_cell        = r_out_max_idx;
    assign o_out.pack_millivolts = r_out_mv;
    assign o_out.invalid_seen    = r_out_inv;
    assign o_out.invalid_cell    = r_out_inv_idx;

    // The cell counter never passes the last cell
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_pos} < LastPos))
        else $error("cell position beyond pack size");

    // A result clears the statistics on the next edge
    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && s1_last) |=> (r_pos == '0 && !r_any && !r_inv_flag))
        else $error("statistics not cleared after result");

    // Min and max indices are both present or both absent
    a_idx_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_min_idx == cvs_pkg::NoIndex) ==
                         (r_out_max_idx == cvs_pkg::NoIndex)))
        else $error("min and max indices disagree");

    // Reported minimum never exceeds reported maximum
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_min <= r_out_max))
        else $error("min above max");

    // A blocked result holds the last cell in the input stage
    a_last_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_last && r_out_valid && !o_out.ready) |=> r_s1_valid)
        else $error("last cell dropped while result blocked");

endmodule
